FILE: rtl/assert_macros.svh
// Assertion macros used by serial_frame_receiver.
// Each macro expects signals clk and rst in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: rtl/sfr_pkg.sv
// Package for the serial frame receiver: codes, state types, reset values.
// No dependencies.
package sfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd2;

  localparam logic [7:0]  START_FIRST_RST  = 8'd170;
  localparam logic [7:0]  START_SECOND_RST = 8'd85;
  localparam logic [15:0] TIMEOUT_RST      = 16'd50000;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_EMPTY    = 3'd1;
  localparam logic [2:0] KIND_CSUM_ERR = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
  localparam logic [2:0] KIND_TOO_LONG = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_SHOW
  } seq_t;

endpackage

FILE: rtl/serial_frame_receiver.sv
// Serial frame receiver: start-pattern hunt, id/len/payload/checksum deframing.
// Depends on sfr_pkg and assert_macros.svh.
// A byte or tick beat is taken while item_stall is low; a single result (error or
// empty frame) is valid the cycle after. A good frame bursts its payload from the
// store one byte at a time (registered read, then output beat), held by result_stall.
// Input is stalled while any result of the current beat is pending.
// Reset (rst, sync): control state cleared, registers to defaults; store untouched.
`include "assert_macros.svh"

module serial_frame_receiver #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          cmd,
  input  logic [7:0]                    rx_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [2:0]                    kind,
  output logic [7:0]                    msg_id,
  output logic [7:0]                    msg_len,
  output logic [7:0]                    payload_byte,
  output logic [5:0]                    byte_index,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfr_pkg::*;

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [6:0] CNT_LIMIT = 7'(MAX_PAYLOAD);
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD);

  logic [7:0]  start_first, start_second;
  logic [15:0] timeout_ticks;

  phase_t      phase, phase_next;
  seq_t        seq, seq_next;
  logic [7:0]  prev_byte, prev_byte_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [5:0]  byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] countdown, countdown_next;

  logic [2:0]  res_kind, res_kind_next;
  logic [7:0]  res_id, res_id_next;
  logic [7:0]  res_len, res_len_next;
  logic [5:0]  res_index, res_index_next;
  logic        res_last, res_last_next;

  logic [7:0]  store [MAX_PAYLOAD];
  logic [7:0]  mem_q;
  logic        mem_we, mem_re, mem_clr;

  logic        accept, timed_out;
  logic [7:0]  sum_add;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (seq != SEQ_IDLE);
  assign cfg_ready  = (seq == SEQ_IDLE);
  assign timed_out  = (phase != PH_IDLE) && (countdown == 16'd0);
  assign sum_add    = running_sum + rx_byte;

  assign result_valid = (seq == SEQ_SHOW);
  assign kind         = res_kind;
  assign msg_id       = res_id;
  assign msg_len      = res_len;
  assign payload_byte = mem_q;
  assign byte_index   = res_index;
  assign last         = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first   <= START_FIRST_RST;
      start_second  <= START_SECOND_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_FIRST:  start_first   <= cfg_data[7:0];
        REG_START_SECOND: start_second  <= cfg_data[7:0];
        REG_TIMEOUT:      timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= SEQ_IDLE;
      phase       <= PH_IDLE;
      prev_byte   <= '0;
      frame_id    <= '0;
      frame_len   <= '0;
      byte_count  <= '0;
      running_sum <= '0;
      countdown   <= '0;
    end else begin
      seq         <= seq_next;
      phase       <= phase_next;
      prev_byte   <= prev_byte_next;
      frame_id    <= frame_id_next;
      frame_len   <= frame_len_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      countdown   <= countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    res_kind  <= res_kind_next;
    res_id    <= res_id_next;
    res_len   <= res_len_next;
    res_index <= res_index_next;
    res_last  <= res_last_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[byte_count[IDX_W-1:0]] <= rx_byte;
    end
    if (mem_re) begin
      mem_q <= store[res_index[IDX_W-1:0]];
    end else if (mem_clr) begin
      mem_q <= '0;
    end
  end

  always_comb begin
    seq_next         = seq;
    phase_next       = phase;
    prev_byte_next   = prev_byte;
    frame_id_next    = frame_id;
    frame_len_next   = frame_len;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    countdown_next   = countdown;
    res_kind_next    = res_kind;
    res_id_next      = res_id;
    res_len_next     = res_len;
    res_index_next   = res_index;
    res_last_next    = res_last;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_clr          = 1'b0;

    unique case (seq)
      SEQ_IDLE: begin
        if (accept) begin
          if (cmd == CMD_TICK) begin
            if (countdown != 16'd0) begin
              countdown_next = countdown - 16'd1;
            end
          end else if (timed_out || phase == PH_IDLE) begin
            if (timed_out) begin
              res_kind_next  = KIND_TIMEOUT;
              res_id_next    = frame_id;
              res_len_next   = frame_len;
              res_index_next = '0;
              res_last_next  = 1'b1;
              mem_clr        = 1'b1;
              seq_next       = SEQ_SHOW;
            end
            if (prev_byte == start_first && rx_byte == start_second) begin
              phase_next       = PH_ID;
              prev_byte_next   = '0;
              frame_id_next    = '0;
              frame_len_next   = '0;
              byte_count_next  = '0;
              running_sum_next = '0;
              countdown_next   = timeout_ticks;
            end else begin
              phase_next     = PH_IDLE;
              prev_byte_next = rx_byte;
            end
          end else begin
            unique case (phase)
              PH_ID: begin
                frame_id_next    = rx_byte;
                running_sum_next = rx_byte;
                phase_next       = PH_LEN;
              end
              PH_LEN: begin
                frame_len_next   = rx_byte;
                running_sum_next = sum_add;
                byte_count_next  = '0;
                if (rx_byte > LEN_LIMIT) begin
                  res_kind_next  = KIND_TOO_LONG;
                  res_id_next    = frame_id;
                  res_len_next   = rx_byte;
                  res_index_next = '0;
                  res_last_next  = 1'b1;
                  mem_clr        = 1'b1;
                  seq_next       = SEQ_SHOW;
                  phase_next     = PH_IDLE;
                end else if (rx_byte == 8'd0) begin
                  phase_next = PH_SUM;
                end else begin
                  phase_next = PH_DATA;
                end
              end
              PH_DATA: begin
                mem_we           = ({1'b0, byte_count} < CNT_LIMIT);
                running_sum_next = sum_add;
                if (({2'b00, byte_count} + 8'd1) >= frame_len) begin
                  phase_next = PH_SUM;
                end else begin
                  byte_count_next = byte_count + 6'd1;
                end
              end
              PH_SUM: begin
                phase_next     = PH_IDLE;
                res_id_next    = frame_id;
                res_len_next   = frame_len;
                res_index_next = '0;
                if (rx_byte != running_sum) begin
                  res_kind_next = KIND_CSUM_ERR;
                  res_last_next = 1'b1;
                  mem_clr       = 1'b1;
                  seq_next      = SEQ_SHOW;
                end else if (frame_len == 8'd0) begin
                  res_kind_next = KIND_EMPTY;
                  res_last_next = 1'b1;
                  mem_clr       = 1'b1;
                  seq_next      = SEQ_SHOW;
                end else begin
                  res_kind_next = KIND_PAYLOAD;
                  seq_next      = SEQ_FETCH;
                end
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
      end
      SEQ_FETCH: begin
        mem_re        = 1'b1;
        res_last_next = (({2'b00, res_index} + 8'd1) == res_len);
        seq_next      = SEQ_SHOW;
      end
      SEQ_SHOW: begin
        if (!result_stall) begin
          if (res_kind == KIND_PAYLOAD && !res_last) begin
            res_index_next = res_index + 6'd1;
            seq_next       = SEQ_FETCH;
          end else begin
            seq_next = SEQ_IDLE;
          end
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  `ASSERT_CLK(a_index_in_frame, (result_valid && kind == KIND_PAYLOAD) |-> ({2'b00, byte_index} < msg_len), "payload index beyond frame length")
  `ASSERT_CLK(a_count_in_frame, (phase == PH_DATA) |-> ({2'b00, byte_count} < frame_len), "byte count beyond frame length")
  `ASSERT_CLK(a_last_ends_run, (result_valid && !result_stall && last) |=> (seq == SEQ_IDLE), "sequencer busy after last beat")
  `ASSERT_CLK(a_index_steps, (result_valid && !result_stall && kind == KIND_PAYLOAD && !last) |=> (seq == SEQ_FETCH && byte_index == $past(byte_index) + 6'd1), "payload index did not advance by one")

endmodule

FILE: tb/testbench.sv
// Self-checking bench for serial_frame_receiver: directed beats, then random framed traffic.
// Predicts result beats (or takes them from flagged rows); compares field by field with DUT.
// Depends on sfr_pkg and the serial_frame_receiver RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int MAXP = MAX_PAYLOAD_DEF;
  localparam int IDXW = (MAXP > 1) ? $clog2(MAXP) : 1;
  localparam int LIMIT = 500000;
  localparam int SETTLE = 10;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] data;
    logic [5:0] idx;
    logic       last;
  } frame_res_t;

  typedef enum logic {ROW_BEAT, ROW_REGS} row_op_t;

  // ROW_REGS rows carry start_first in id, start_second in len, timeout in tmo
  typedef struct packed {
    row_op_t     op;
    logic        c;
    logic [7:0]  b;
    logic        typed;
    logic [2:0]  k;
    logic [7:0]  id;
    logic [7:0]  len;
    logic [15:0] tmo;
  } stim_row_t;

  logic clk, rst;
  logic item_valid, item_stall, cmd;
  logic [7:0] rx_byte;
  logic result_valid, result_stall;
  logic [2:0] kind;
  logic [7:0] msg_id, msg_len, payload_byte;
  logic [5:0] byte_index;
  logic last;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic beat_typed;
  frame_res_t beat_typed_res;

  // predictor state
  phase_t rx_phase;
  logic [7:0] prev_b, cur_id, cur_len, sum_acc;
  logic [5:0] cnt;
  logic [15:0] ticks_left;
  logic [7:0] store_mem [MAXP];
  logic [7:0] cfg_first, cfg_second;
  logic [15:0] cfg_timeout;
  frame_res_t due_results[$];

  int fails = 0;
  int beats_in = 0;
  int results_seen = 0;
  int framed_bytes = 0;
  int kind_seen [5] = '{0, 0, 0, 0, 0};
  int sender_idle_pct = 6;
  int recv_idle_pct = 75;
  int tick_pct = 10;
  int unsigned cycle_count = 0;

  serial_frame_receiver dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .cmd(cmd), .rx_byte(rx_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .msg_id(msg_id), .msg_len(msg_len), .payload_byte(payload_byte),
    .byte_index(byte_index), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic frame_res_t mk(logic [2:0] k, logic [7:0] d, logic [5:0] ix, logic l);
    return {k, cur_id, cur_len, d, ix, l};
  endfunction

  function automatic void hunt_start(logic [7:0] b);
    if (prev_b == cfg_first && b == cfg_second) begin
      rx_phase = PH_ID;
      prev_b = 8'h00;
      cur_id = 8'h00;
      cur_len = 8'h00;
      cnt = 6'd0;
      sum_acc = 8'h00;
      ticks_left = cfg_timeout;
    end else begin
      prev_b = b;
    end
  endfunction

  function automatic void deframe_beat(logic c, logic [7:0] b, logic typed, frame_res_t tres);
    frame_res_t got[$];
    if (c == CMD_TICK) begin
      if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
    end else if (rx_phase != PH_IDLE && ticks_left == 16'd0) begin
      got.push_back(mk(KIND_TIMEOUT, 8'h00, 6'd0, 1'b1));
      rx_phase = PH_IDLE;
      hunt_start(b);
    end else begin
      case (rx_phase)
        PH_ID: begin
          cur_id = b;
          sum_acc = b;
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          cur_len = b;
          sum_acc = sum_acc + b;
          cnt = 6'd0;
          if (int'(b) > MAXP) begin
            got.push_back(mk(KIND_TOO_LONG, 8'h00, 6'd0, 1'b1));
            rx_phase = PH_IDLE;
          end else begin
            rx_phase = (b == 8'h00) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          if (int'(cnt) < MAXP) store_mem[cnt[IDXW-1:0]] = b;
          sum_acc = sum_acc + b;
          if (int'(cnt) + 1 >= int'(cur_len)) rx_phase = PH_SUM;
          else cnt = cnt + 6'd1;
        end
        PH_SUM: begin
          rx_phase = PH_IDLE;
          if (b != sum_acc) begin
            got.push_back(mk(KIND_CSUM_ERR, 8'h00, 6'd0, 1'b1));
          end else if (cur_len == 8'h00) begin
            got.push_back(mk(KIND_EMPTY, 8'h00, 6'd0, 1'b1));
          end else begin
            for (int i = 0; i < int'(cur_len) && i < MAXP; i++)
              got.push_back(mk(KIND_PAYLOAD, store_mem[IDXW'(i)], 6'(i),
                               (i + 1 == int'(cur_len))));
          end
        end
        default: begin
          rx_phase = PH_IDLE;
          hunt_start(b);
        end
      endcase
    end
    if (typed) due_results.push_back(tres);
    else foreach (got[i]) due_results.push_back(got[i]);
  endfunction

  always @(posedge clk) begin : monitor
    frame_res_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_FIRST: cfg_first = cfg_data[7:0];
          REG_START_SECOND: cfg_second = cfg_data[7:0];
          REG_TIMEOUT: cfg_timeout = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        deframe_beat(cmd, rx_byte, beat_typed, beat_typed_res);
        beats_in++;
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("unexpected result beat: kind %0d id %0h", kind, msg_id);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (want.kind <= KIND_TOO_LONG) kind_seen[want.kind]++;
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            fails++;
          end
          if (msg_id !== want.id) begin
            $error("msg_id: expected %0h, got %0h", want.id, msg_id);
            fails++;
          end
          if (msg_len !== want.len) begin
            $error("msg_len: expected %0h, got %0h", want.len, msg_len);
            fails++;
          end
          if (payload_byte !== want.data) begin
            $error("payload_byte: expected %0h, got %0h", want.data, payload_byte);
            fails++;
          end
          if (byte_index !== want.idx) begin
            $error("byte_index: expected %0d, got %0d", want.idx, byte_index);
            fails++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            fails++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("serial_frame_receiver test failed");
      $finish;
    end
  end

  task automatic send_item(logic c, logic [7:0] b, logic typed, frame_res_t tres);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    beat_typed <= typed;
    beat_typed_res <= tres;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(CMD_BYTE, b, 1'b0, '0);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom), 1'b0, '0);
  endtask

  task automatic frame_byte(logic [7:0] b);
    while ($urandom_range(99) < tick_pct) send_tick();
    send_byte(b);
    framed_bytes++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(logic [7:0] f, logic [7:0] s, logic [15:0] t);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx[0] = REG_START_FIRST;
    idx[1] = REG_START_SECOND;
    idx[2] = REG_TIMEOUT;
    val[0] = {8'($urandom), f};
    val[1] = {8'($urandom), s};
    val[2] = t;
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[2'(i)];
      cfg_data <= val[2'(i)];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_frame();
    int shape;
    logic [7:0] fid, flen, csum, pb;
    repeat ($urandom_range(2)) begin
      if ($urandom_range(3) == 0) send_tick();
      else send_byte(8'($urandom));
    end
    frame_byte(cfg_first);
    frame_byte(cfg_second);
    shape = $urandom_range(99);
    fid = 8'($urandom);
    if (shape < 8) flen = 8'd0;
    else if (shape < 16) flen = 8'(MAXP);
    else if (shape < 24) flen = 8'($urandom_range(MAXP + 1, 255));
    else if (shape < 30) begin
      repeat ($urandom_range(1, 4)) frame_byte(8'($urandom));
      return;
    end else flen = 8'($urandom_range(1, 8));
    frame_byte(fid);
    frame_byte(flen);
    if (int'(flen) > MAXP) return;
    csum = fid + flen;
    repeat (int'(flen)) begin
      pb = 8'($urandom);
      csum = csum + pb;
      frame_byte(pb);
    end
    if ($urandom_range(99) < 12) csum = csum ^ 8'($urandom_range(1, 255));
    frame_byte(csum);
  endtask

  function automatic stim_row_t beat(logic c, logic [7:0] b);
    return {ROW_BEAT, c, b, 1'b0, 3'd0, 8'h00, 8'h00, 16'h0000};
  endfunction

  function automatic stim_row_t flagged(logic [7:0] b, logic [2:0] k, logic [7:0] id,
                                        logic [7:0] len);
    return {ROW_BEAT, CMD_BYTE, b, 1'b1, k, id, len, 16'h0000};
  endfunction

  function automatic stim_row_t regs(logic [7:0] f, logic [7:0] s, logic [15:0] t);
    return {ROW_REGS, CMD_BYTE, 8'h00, 1'b0, 3'd0, f, s, t};
  endfunction

  initial begin
    stim_row_t dir_table[$];
    int target;
    rst = 1'b1;
    item_valid = 1'b0;
    cmd = CMD_BYTE;
    rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_START_FIRST;
    cfg_data = '0;
    result_stall = 1'b0;
    beat_typed = 1'b0;
    beat_typed_res = '0;
    rx_phase = PH_IDLE;
    prev_b = 8'h00;
    cur_id = 8'h00;
    cur_len = 8'h00;
    sum_acc = 8'h00;
    cnt = 6'd0;
    ticks_left = 16'd0;
    cfg_first = START_FIRST_RST;
    cfg_second = START_SECOND_RST;
    cfg_timeout = TIMEOUT_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset pattern and timeout first, then zero and minimum timeouts
    dir_table.push_back(beat(CMD_BYTE, 8'h00));
    dir_table.push_back(beat(CMD_TICK, 8'hFF));
    dir_table.push_back(beat(CMD_BYTE, 8'hAA));
    dir_table.push_back(beat(CMD_BYTE, 8'h55));
    dir_table.push_back(beat(CMD_BYTE, 8'h12));
    dir_table.push_back(beat(CMD_BYTE, 8'h00));
    dir_table.push_back(flagged(8'h12, KIND_EMPTY, 8'h12, 8'h00));
    dir_table.push_back(beat(CMD_BYTE, 8'hAA));
    dir_table.push_back(beat(CMD_BYTE, 8'h55));
    dir_table.push_back(beat(CMD_BYTE, 8'hFF));
    dir_table.push_back(flagged(8'h21, KIND_TOO_LONG, 8'hFF, 8'h21));
    dir_table.push_back(beat(CMD_BYTE, 8'hAA));
    dir_table.push_back(beat(CMD_BYTE, 8'h55));
    dir_table.push_back(beat(CMD_BYTE, 8'h01));
    dir_table.push_back(beat(CMD_BYTE, 8'h02));
    dir_table.push_back(beat(CMD_BYTE, 8'hFF));
    dir_table.push_back(beat(CMD_BYTE, 8'h00));
    dir_table.push_back(flagged(8'h00, KIND_CSUM_ERR, 8'h01, 8'h02));
    dir_table.push_back(regs(8'hAA, 8'h55, 16'd0));
    dir_table.push_back(beat(CMD_BYTE, 8'hAA));
    dir_table.push_back(beat(CMD_BYTE, 8'h55));
    dir_table.push_back(flagged(8'h07, KIND_TIMEOUT, 8'h00, 8'h00));
    dir_table.push_back(regs(8'h00, 8'hFF, 16'd1));
    dir_table.push_back(beat(CMD_BYTE, 8'h00));
    dir_table.push_back(beat(CMD_BYTE, 8'hFF));
    dir_table.push_back(beat(CMD_BYTE, 8'h7E));
    dir_table.push_back(beat(CMD_TICK, 8'h00));
    dir_table.push_back(flagged(8'h01, KIND_TIMEOUT, 8'h7E, 8'h00));

    foreach (dir_table[i]) begin
      if (dir_table[i].op == ROW_REGS)
        program_regs(dir_table[i].id, dir_table[i].len, dir_table[i].tmo);
      else
        send_item(dir_table[i].c, dir_table[i].b, dir_table[i].typed,
                  {dir_table[i].k, dir_table[i].id, dir_table[i].len, 8'h00, 6'd0, 1'b1});
    end

    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = (p == 0) ? 6 : (p == 1) ? 75 : 0;
      recv_idle_pct = (p == 0) ? 75 : (p == 1) ? 6 : 0;
      for (int h = 0; h < 2; h++) begin
        case (p * 2 + h)
          0: begin
            tick_pct = 10;
            program_regs(8'hAA, 8'h55, 16'hFFFF);
          end
          1: begin
            tick_pct = 20;
            program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 8)));
          end
          2: begin
            tick_pct = 8;
            program_regs(8'hFF, 8'h00, 16'd1);
          end
          3: begin
            tick_pct = 15;
            program_regs(8'h55, 8'hAA, 16'($urandom_range(2, 30)));
          end
          4: begin
            tick_pct = 10;
            program_regs(8'($urandom), 8'($urandom), 16'd1000);
          end
          default: begin
            tick_pct = 20;
            program_regs(8'h3C, 8'hC3, 16'($urandom_range(1, 16)));
          end
        endcase
        target = framed_bytes + 40;
        while (framed_bytes < target) random_frame();
      end
    end
    drain();

    $display("Run covered %0d input beats (%0d framed bytes) and %0d result beats",
             beats_in, framed_bytes, results_seen);
    $display("Result kinds: %0d payload, %0d empty, %0d bad checksum, %0d timeout, %0d too long",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (fails == 0) begin
      $display("serial_frame_receiver test passed");
    end else begin
      $display("serial_frame_receiver test failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/serial_frame_receiver.sv
tb/testbench.sv
